// File: rtl/wfcs_pkg.sv
`timescale 1ns / 1ps

package wfcs_pkg;

    // Field widths
    localparam int ReqTypeW = 2;
    localparam int KeyCodeW = 4;
    localparam int SegW     = 8;
    localparam int CountW   = 7;
    localparam int PpuW     = 8;
    localparam int HoldW    = 16;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 16;

    // Request kinds
    localparam logic [ReqTypeW-1:0] REQ_KEY   = 2'd0;
    localparam logic [ReqTypeW-1:0] REQ_PULSE = 2'd1;
    localparam logic [ReqTypeW-1:0] REQ_TICK  = 2'd2;

    // Key codes
    localparam logic [KeyCodeW-1:0] KEY_STAR = 4'd10;
    localparam logic [KeyCodeW-1:0] KEY_HASH = 4'd11;

    // Register indexes
    localparam logic [CfgIdxW-1:0] CFG_PPU  = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_HOLD = 1'd1;

    // Register reset values
    localparam logic [PpuW-1:0]  PPU_RESET  = 8'd4;
    localparam logic [HoldW-1:0] HOLD_RESET = 16'd150;

    localparam logic [CountW-1:0] SHOWN_MAX = 7'd99;
    localparam logic [CountW-1:0] COUNT_MAX = 7'd127;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_WIRES_D1 = 3'd1,
        MODE_WIRES_D2 = 3'd2,
        MODE_LEN_D1   = 3'd3,
        MODE_LEN_D2   = 3'd4,
        MODE_FEED     = 3'd5,
        MODE_CUT      = 3'd6
    } t_mode;

    // Accepted request as it leaves the input register
    typedef struct packed {
        logic                valid;
        logic [ReqTypeW-1:0] req_type;
        logic [KeyCodeW-1:0] key_code;
    } t_step;

    // Result of one request, before segment encoding
    typedef struct packed {
        logic              cutter_on;
        logic [CountW-1:0] shown;
        logic              running;
        logic              batch_done;
    } t_result;

    // Common-cathode patterns, digits 0 to 9
    localparam logic [SegW-1:0] SEG_TABLE [10] = '{
        8'b11111100, 8'b01100000, 8'b11011010, 8'b11110010, 8'b01100110,
        8'b10110110, 8'b10111110, 8'b11100000, 8'b11111110, 8'b11110110
    };

    // Tens digit of a value up to 99 by reciprocal multiply (205 / 2048)
    function automatic logic [3:0] tens_of(input logic [CountW-1:0] v);
        logic [14:0] prod;
        prod = 15'(v) * 15'd205;
        return prod[14:11];
    endfunction

endpackage

// File: rtl/wfcs_if.sv
`timescale 1ns / 1ps

// Request channel
interface wfcs_in_if;
    logic                              valid;
    logic                              ready;
    logic [wfcs_pkg::ReqTypeW-1:0]     req_type;
    logic [wfcs_pkg::KeyCodeW-1:0]     key_code;

    modport source (output valid, output req_type, output key_code, input ready);
    modport sink   (input valid, input req_type, input key_code, output ready);
endinterface

// Result channel
interface wfcs_out_if;
    logic                          valid;
    logic                          ready;
    logic                          cutter_on;
    logic [wfcs_pkg::SegW-1:0]     tens_segments;
    logic [wfcs_pkg::SegW-1:0]     units_segments;
    logic                          running;
    logic                          batch_done;

    modport source (output valid, output cutter_on, output tens_segments,
                    output units_segments, output running, output batch_done,
                    input ready);
    modport sink   (input valid, input cutter_on, input tens_segments,
                    input units_segments, input running, input batch_done,
                    output ready);
endinterface

// Configuration write channel
interface wfcs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wfcs_pkg::CfgIdxW-1:0]      index;
    logic [wfcs_pkg::CfgDataW-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/wfcs_in_stage.sv
`timescale 1ns / 1ps

module wfcs_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wfcs_in_if.sink           i_in,
    input  logic              i_advance,
    output wfcs_pkg::t_step   o_step
);

    logic                          r_valid;
    logic [wfcs_pkg::ReqTypeW-1:0] r_req_type;
    logic [wfcs_pkg::KeyCodeW-1:0] r_key_code;
    logic                          take;

    // Free when empty or when the held request moves on this cycle
    assign i_in.ready = !r_valid || i_advance;
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req_type <= i_in.req_type;
            r_key_code <= i_in.key_code;
        end
    end

    // A request is processed when it is held and the result register is free
    assign o_step.valid    = r_valid && i_advance;
    assign o_step.req_type = r_req_type;
    assign o_step.key_code = r_key_code;

endmodule

// File: rtl/wfcs_ctrl.sv
`timescale 1ns / 1ps

module wfcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wfcs_cfg_if.sink          i_cfg,
    input  wfcs_pkg::t_step   i_step,
    output wfcs_pkg::t_result o_result
);

    localparam int CW = wfcs_pkg::CountW;

    // Configuration registers
    logic [wfcs_pkg::PpuW-1:0]  r_ppu;
    logic [wfcs_pkg::HoldW-1:0] r_hold_cfg;

    // Sequencer state
    wfcs_pkg::t_mode            r_mode, n_mode;
    logic [3:0]                 r_first_digit, n_first_digit;
    logic [CW-1:0]              r_wires_target, n_wires_target;
    logic [CW-1:0]              r_length_target, n_length_target;
    logic [wfcs_pkg::PpuW-1:0]  r_pulse_div, n_pulse_div;
    logic [CW-1:0]              r_length_count, n_length_count;
    logic [CW-1:0]              r_wires_done, n_wires_done;
    logic [wfcs_pkg::HoldW-1:0] r_hold_timer, n_hold_timer;
    logic                       r_cutter, n_cutter;
    logic [CW-1:0]              r_shown, n_shown;
    logic                       n_done;

    assign i_cfg.ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppu      <= wfcs_pkg::PPU_RESET;
            r_hold_cfg <= wfcs_pkg::HOLD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                wfcs_pkg::CFG_PPU:  r_ppu      <= i_cfg.data[wfcs_pkg::PpuW-1:0];
                wfcs_pkg::CFG_HOLD: r_hold_cfg <= i_cfg.data[wfcs_pkg::HoldW-1:0];
                default: ;
            endcase
        end
    end

    // Next state for one request
    always_comb begin
        logic                      digit;
        logic [CW-1:0]             entered;
        logic [wfcs_pkg::PpuW-1:0] pd_inc;
        logic [CW-1:0]             lc_inc;
        logic [CW-1:0]             wd_inc;

        n_mode          = r_mode;
        n_first_digit   = r_first_digit;
        n_wires_target  = r_wires_target;
        n_length_target = r_length_target;
        n_pulse_div     = r_pulse_div;
        n_length_count  = r_length_count;
        n_wires_done    = r_wires_done;
        n_hold_timer    = r_hold_timer;
        n_cutter        = r_cutter;
        n_shown         = r_shown;
        n_done          = 1'b0;

        digit   = i_step.key_code inside {[4'd0:4'd9]};
        // first_digit * 10 + key, at most 99
        entered = CW'({r_first_digit, 3'b000}) + CW'({r_first_digit, 1'b0})
                  + CW'(i_step.key_code);
        pd_inc  = r_pulse_div + 1'b1;
        lc_inc  = (r_length_count < wfcs_pkg::COUNT_MAX) ? r_length_count + 1'b1
                                                         : r_length_count;
        wd_inc  = r_wires_done + 1'b1;

        case (i_step.req_type)
            wfcs_pkg::REQ_KEY: begin
                case (r_mode)
                    wfcs_pkg::MODE_IDLE: begin
                        if (i_step.key_code == wfcs_pkg::KEY_STAR) begin
                            n_mode = wfcs_pkg::MODE_WIRES_D1;
                        end else if (i_step.key_code == wfcs_pkg::KEY_HASH) begin
                            n_mode = wfcs_pkg::MODE_LEN_D1;
                        end
                    end
                    wfcs_pkg::MODE_WIRES_D1: begin
                        if (digit) begin
                            n_first_digit = i_step.key_code;
                            n_mode        = wfcs_pkg::MODE_WIRES_D2;
                        end
                    end
                    wfcs_pkg::MODE_LEN_D1: begin
                        if (digit) begin
                            n_first_digit = i_step.key_code;
                            n_mode        = wfcs_pkg::MODE_LEN_D2;
                        end
                    end
                    wfcs_pkg::MODE_WIRES_D2: begin
                        if (digit) begin
                            n_wires_target = entered;
                            n_shown        = entered;
                            n_mode         = wfcs_pkg::MODE_IDLE;
                        end
                    end
                    wfcs_pkg::MODE_LEN_D2: begin
                        // Length entered: start the batch, or return to idle if the wire count is zero
                        if (digit) begin
                            n_length_target = entered;
                            n_shown         = '0;
                            n_length_count  = '0;
                            n_pulse_div     = '0;
                            n_wires_done    = '0;
                            if (r_wires_target == '0) begin
                                n_mode = wfcs_pkg::MODE_IDLE;
                            end else if (entered == '0) begin
                                n_mode       = wfcs_pkg::MODE_CUT;
                                n_cutter     = 1'b1;
                                n_hold_timer = r_hold_cfg;
                            end else begin
                                n_mode = wfcs_pkg::MODE_FEED;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            wfcs_pkg::REQ_PULSE: begin
                if (r_mode == wfcs_pkg::MODE_FEED) begin
                    n_pulse_div = pd_inc;
                    // A zero divider acts as one
                    if (pd_inc >= r_ppu) begin
                        n_pulse_div    = '0;
                        n_length_count = lc_inc;
                        n_shown        = lc_inc;
                        if (lc_inc >= r_length_target) begin
                            n_mode       = wfcs_pkg::MODE_CUT;
                            n_cutter     = 1'b1;
                            n_hold_timer = r_hold_cfg;
                        end
                    end
                end
            end
            wfcs_pkg::REQ_TICK: begin
                if (r_mode == wfcs_pkg::MODE_CUT) begin
                    if (r_hold_timer > 16'd1) begin
                        n_hold_timer = r_hold_timer - 1'b1;
                    end else begin
                        // Count the wire; release the cutter and finish or feed the next, or re-arm it at zero length
                        n_hold_timer   = '0;
                        n_cutter       = 1'b0;
                        n_length_count = '0;
                        n_pulse_div    = '0;
                        n_shown        = '0;
                        n_wires_done   = wd_inc;
                        if (wd_inc >= r_wires_target) begin
                            n_wires_done = '0;
                            n_mode       = wfcs_pkg::MODE_IDLE;
                            n_done       = 1'b1;
                        end else if (r_length_target == '0) begin
                            n_cutter     = 1'b1;
                            n_hold_timer = r_hold_cfg;
                        end else begin
                            n_mode = wfcs_pkg::MODE_FEED;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= wfcs_pkg::MODE_IDLE;
            r_first_digit   <= '0;
            r_wires_target  <= '0;
            r_length_target <= '0;
            r_pulse_div     <= '0;
            r_length_count  <= '0;
            r_wires_done    <= '0;
            r_hold_timer    <= '0;
            r_cutter        <= 1'b0;
            r_shown         <= '0;
        end else if (i_step.valid) begin
            r_mode          <= n_mode;
            r_first_digit   <= n_first_digit;
            r_wires_target  <= n_wires_target;
            r_length_target <= n_length_target;
            r_pulse_div     <= n_pulse_div;
            r_length_count  <= n_length_count;
            r_wires_done    <= n_wires_done;
            r_hold_timer    <= n_hold_timer;
            r_cutter        <= n_cutter;
            r_shown         <= n_shown;
        end
    end

    // Result seen after this request
    assign o_result.cutter_on  = n_cutter;
    assign o_result.shown      = n_shown;
    assign o_result.running    = (n_mode == wfcs_pkg::MODE_FEED) ||
                                 (n_mode == wfcs_pkg::MODE_CUT);
    assign o_result.batch_done = n_done;

endmodule

// File: rtl/wfcs_out_stage.sv
`timescale 1ns / 1ps

module wfcs_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wfcs_pkg::t_result i_result,
    output logic              o_free,
    wfcs_out_if.source        o_out
);

    logic                      r_valid;
    logic                      r_cutter;
    logic [wfcs_pkg::SegW-1:0] r_tens;
    logic [wfcs_pkg::SegW-1:0] r_units;
    logic                      r_running;
    logic                      r_done;

    logic [wfcs_pkg::CountW-1:0] sat;
    logic [3:0]                  tens;
    logic [3:0]                  units;
    logic [wfcs_pkg::CountW-1:0] tens_x10;

    assign o_free = !r_valid || o_out.ready;

    // Saturate at 99 and split into two digits
    assign sat      = (i_result.shown > wfcs_pkg::SHOWN_MAX) ? wfcs_pkg::SHOWN_MAX
                                                             : i_result.shown;
    assign tens     = wfcs_pkg::tens_of(sat);
    assign tens_x10 = wfcs_pkg::CountW'({tens, 3'b000}) + wfcs_pkg::CountW'({tens, 1'b0});
    assign units    = 4'(sat - tens_x10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cutter  <= i_result.cutter_on;
            r_tens    <= wfcs_pkg::SEG_TABLE[tens];
            r_units   <= wfcs_pkg::SEG_TABLE[units];
            r_running <= i_result.running;
            r_done    <= i_result.batch_done;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.cutter_on      = r_cutter;
    assign o_out.tens_segments  = r_tens;
    assign o_out.units_segments = r_units;
    assign o_out.running        = r_running;
    assign o_out.batch_done     = r_done;

endmodule

// File: rtl/wire_feed_cut_sequencer_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                                              Handshake
// i_in     in   req_type[1:0], key_code[3:0]                         valid/ready
// o_out    out  cutter_on, tens_segments[7:0], units_segments[7:0],  valid/ready
//               running, batch_done
// i_cfg    in   index[0] (0 pulses_per_unit, 1 cut_hold_ticks),      valid/ready
//               data[15:0]
//
// One request per cycle while the result register is not stalled; a result passes through
// the input register, then the result register, loaded with the combinational state update.
// Synchronous active-low reset restores idle and the register defaults.
// While the result register is stalled one further request is held in the input
// register; after that i_in.ready drops. Configuration writes are always ready.

module wire_feed_cut_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wfcs_in_if.sink     i_in,
    wfcs_out_if.source  o_out,
    wfcs_cfg_if.sink    i_cfg
);

    wfcs_pkg::t_step   step;
    wfcs_pkg::t_result result;
    logic              out_free;

    wfcs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (out_free),
        .o_step    (step)
    );

    wfcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_step   (step),
        .o_result (result)
    );

    wfcs_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step.valid),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

// File: rtl/wfcs_checker.sv
`timescale 1ns / 1ps

module wfcs_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_cutter_on,
    input logic [wfcs_pkg::SegW-1:0] i_tens,
    input logic [wfcs_pkg::SegW-1:0] i_units,
    input logic                      i_running,
    input logic                      i_batch_done
);

    // A stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_cutter_on) && $stable(i_tens) &&
            $stable(i_units) && $stable(i_running) && $stable(i_batch_done))
        else $error("result changed while stalled");

    // The cutter is only driven inside a batch
    a_cut_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_cutter_on |-> i_running)
        else $error("cutter on outside a batch");

    // Finishing a batch leaves it idle with the cutter released
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_batch_done |-> !i_running && !i_cutter_on)
        else $error("batch done while still running");

    // A finished batch shows zero on both digits
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_batch_done |->
            i_tens == wfcs_pkg::SEG_TABLE[0] && i_units == wfcs_pkg::SEG_TABLE[0])
        else $error("display not cleared at batch end");

endmodule

bind wire_feed_cut_sequencer_top wfcs_checker u_wfcs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_cutter_on  (o_out.cutter_on),
    .i_tens       (o_out.tens_segments),
    .i_units      (o_out.units_segments),
    .i_running    (o_out.running),
    .i_batch_done (o_out.batch_done)
);

// File: tb/wire_feed_cut_sequencer_top_tb.sv
`timescale 1ns / 1ps

module wire_feed_cut_sequencer_top_tb;
    import wfcs_pkg::*;

    localparam logic [ReqTypeW-1:0] REQ_SPARE = 2'd3;   // unused request kind
    localparam int IDLE_PCT      = 18;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 40;
    localparam int REPORT_MAX    = 10;

    // Common-cathode patterns, digits 0 to 9
    localparam logic [SegW-1:0] DIGIT_SEG [10] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
    };

    typedef struct packed {
        logic [ReqTypeW-1:0] kind;
        logic [KeyCodeW-1:0] key;
    } t_request;

    typedef struct packed {
        logic            cutter;
        logic [SegW-1:0] tens;
        logic [SegW-1:0] units;
        logic            running;
        logic            done;
    } t_panel;

    logic i_clk;
    logic i_rst_n;

    wfcs_in_if  req_bus ();
    wfcs_out_if panel_bus ();
    wfcs_cfg_if cfg_bus ();

    wire_feed_cut_sequencer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus),
        .o_out   (panel_bus),
        .i_cfg   (cfg_bus)
    );

    // Request and result bookkeeping
    t_request requests_pending [$];
    t_panel   panel_due [$];
    int       outstanding = 0;
    int       mismatches = 0;
    int       idle_run = 0;
    bit       calm = 1'b0;
    int       noise_pct = 0;
    int       wires_typed = 0;
    int       made = 0;

    // Sequencer state as the testbench sees it
    logic [PpuW-1:0]   ppu_cfg = PPU_RESET;
    logic [HoldW-1:0]  hold_cfg = HOLD_RESET;
    t_mode             mode_now = MODE_IDLE;
    logic [3:0]        first_key = '0;
    logic [CountW-1:0] wires_goal = '0;
    logic [CountW-1:0] length_goal = '0;
    logic [PpuW-1:0]   unit_div = '0;
    logic [CountW-1:0] length_now = '0;
    logic [CountW-1:0] wires_cut = '0;
    logic [HoldW-1:0]  hold_left = '0;
    logic              cutter_now = 1'b0;
    logic [CountW-1:0] shown_now = '0;

    function automatic void arm_cutter();
        mode_now   = MODE_CUT;
        cutter_now = 1'b1;
        hold_left  = hold_cfg;
    endfunction

    // Advance the state by one request and return the panel it leaves
    function automatic t_panel panel_after(input logic [ReqTypeW-1:0] kind,
                                           input logic [KeyCodeW-1:0] key);
        t_panel            p;
        logic              finished;
        logic [CountW-1:0] shown;
        finished = 1'b0;
        case (kind)
            REQ_KEY: begin
                case (mode_now)
                    MODE_IDLE: begin
                        if (key == KEY_STAR) mode_now = MODE_WIRES_D1;
                        else if (key == KEY_HASH) mode_now = MODE_LEN_D1;
                    end
                    MODE_WIRES_D1, MODE_LEN_D1: begin
                        if (key <= 4'd9) begin
                            first_key = key;
                            mode_now  = (mode_now == MODE_WIRES_D1) ? MODE_WIRES_D2
                                                                    : MODE_LEN_D2;
                        end
                    end
                    MODE_WIRES_D2: begin
                        if (key <= 4'd9) begin
                            wires_goal = 7'(first_key) * 7'd10 + 7'(key);
                            shown_now  = wires_goal;
                            mode_now   = MODE_IDLE;
                        end
                    end
                    MODE_LEN_D2: begin
                        if (key <= 4'd9) begin
                            length_goal = 7'(first_key) * 7'd10 + 7'(key);
                            shown_now   = '0;
                            length_now  = '0;
                            unit_div    = '0;
                            wires_cut   = '0;
                            if (wires_goal == 0) mode_now = MODE_IDLE;
                            else if (length_goal == 0) arm_cutter();
                            else mode_now = MODE_FEED;
                        end
                    end
                    default: ;
                endcase
            end
            REQ_PULSE: begin
                if (mode_now == MODE_FEED) begin
                    unit_div = unit_div + 8'd1;
                    // a divider of zero behaves as one
                    if (unit_div >= ppu_cfg) begin
                        unit_div = '0;
                        if (length_now < COUNT_MAX) length_now = length_now + 7'd1;
                        shown_now = length_now;
                        if (length_now >= length_goal) arm_cutter();
                    end
                end
            end
            REQ_TICK: begin
                if (mode_now == MODE_CUT) begin
                    if (hold_left > 1) begin
                        hold_left = hold_left - 16'd1;
                    end else begin
                        // count the wire; release the cutter and finish or feed the next, or re-arm it at zero length
                        hold_left  = '0;
                        cutter_now = 1'b0;
                        length_now = '0;
                        unit_div   = '0;
                        shown_now  = '0;
                        wires_cut  = wires_cut + 7'd1;
                        if (wires_cut >= wires_goal) begin
                            wires_cut = '0;
                            mode_now  = MODE_IDLE;
                            finished  = 1'b1;
                        end else if (length_goal == 0) begin
                            arm_cutter();
                        end else begin
                            mode_now = MODE_FEED;
                        end
                    end
                end
            end
            default: ;
        endcase
        shown     = (shown_now > SHOWN_MAX) ? SHOWN_MAX : shown_now;
        p.cutter  = cutter_now;
        p.tens    = DIGIT_SEG[shown / 10];
        p.units   = DIGIT_SEG[shown % 10];
        p.running = (mode_now == MODE_FEED) || (mode_now == MODE_CUT);
        p.done    = finished;
        return p;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Request driver
    always @(posedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                panel_due.push_back(panel_after(req_bus.req_type, req_bus.key_code));
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (requests_pending.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = requests_pending.pop_front();
                    outstanding++;
                    req_bus.valid    <= 1'b1;
                    req_bus.req_type <= nxt.kind;
                    req_bus.key_code <= nxt.key;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_panel want;
        t_panel got;
        if (!i_rst_n) begin
            panel_bus.ready <= 1'b0;
        end else begin
            if (panel_bus.valid && panel_bus.ready) begin
                got.cutter  = panel_bus.cutter_on;
                got.tens    = panel_bus.tens_segments;
                got.units   = panel_bus.units_segments;
                got.running = panel_bus.running;
                got.done    = panel_bus.batch_done;
                if (panel_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: cutter %b tens %h units %h running %b done %b",
                                 got.cutter, got.tens, got.units, got.running, got.done);
                end else begin
                    want = panel_due.pop_front();
                    outstanding--;
                    if (want !== got) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"result mismatch (expected/actual): cutter %b/%b ",
                                      "tens %h/%h units %h/%h running %b/%b done %b/%b"},
                                     want.cutter, got.cutter, want.tens, got.tens,
                                     want.units, got.units, want.running, got.running,
                                     want.done, got.done);
                    end
                end
            end
            panel_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog on channel activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) ||
            (panel_bus.valid && panel_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("wire_feed_cut_sequencer_top_tb failed");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    task automatic push_req(input logic [ReqTypeW-1:0] kind, input logic [KeyCodeW-1:0] key);
        t_request r;
        r.kind = kind;
        r.key  = key;
        requests_pending.push_back(r);
    endtask

    task automatic push_junk_key();
        push_req(REQ_KEY, 4'($urandom_range(15, 10)));
    endtask

    // Star or hash followed by two digits, stray keys now and then
    task automatic push_entry(input logic [KeyCodeW-1:0] lead, input int value);
        push_req(REQ_KEY, lead);
        if ($urandom_range(99) < noise_pct) push_junk_key();
        push_req(REQ_KEY, 4'(value / 10));
        if ($urandom_range(99) < noise_pct) push_junk_key();
        push_req(REQ_KEY, 4'(value % 10));
        if (lead == KEY_STAR) wires_typed = value;
    endtask

    // One stray request that the current phase of the work ignores
    task automatic push_noise(input bit with_pulse, input bit with_tick, input bit any_key);
        int sel;
        int k;
        sel = $urandom_range(3);
        k   = $urandom_range(13);
        if (sel == 0) push_req(REQ_KEY, any_key ? 4'($urandom_range(15))
                                                : 4'((k < 10) ? k : k + 2));
        else if (sel == 1 && with_pulse) push_req(REQ_PULSE, 4'($urandom_range(15)));
        else if (sel == 2 && with_tick) push_req(REQ_TICK, 4'($urandom_range(15)));
        else push_req(REQ_SPARE, 4'($urandom_range(15)));
    endtask

    // Full batch: entries, then pulses and ticks enough for every wire
    task automatic queue_batch(input int wires, input int length, input bit retype);
        int per_unit;
        int per_cut;
        per_unit = (ppu_cfg == 0) ? 1 : int'(ppu_cfg);
        per_cut  = (hold_cfg == 0) ? 1 : int'(hold_cfg);
        if (retype) begin
            push_entry(KEY_STAR, wires);
            made += 3;
        end
        push_entry(KEY_HASH, length);
        made += 3;
        for (int w = 0; w < wires_typed; w++) begin
            for (int p = 0; p < per_unit * length; p++) begin
                if ($urandom_range(99) < noise_pct) push_noise(1'b0, 1'b1, 1'b1);
                push_req(REQ_PULSE, 4'($urandom_range(15)));
            end
            for (int t = 0; t < per_cut; t++) begin
                if ($urandom_range(99) < noise_pct) push_noise(1'b1, 1'b0, 1'b1);
                push_req(REQ_TICK, 4'($urandom_range(15)));
            end
            made += per_unit * length + per_cut;
        end
    endtask

    // Hold off until every request has been answered
    task automatic wait_drained();
        while (requests_pending.size() != 0 || outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        if (idx == CFG_PPU) ppu_cfg = value[PpuW-1:0];
        else hold_cfg = value;
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stimulus sequence
    initial begin
        int phase_no;
        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = REQ_KEY;
        req_bus.key_code   = '0;
        panel_bus.ready    = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_PPU;
        cfg_bus.data       = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stray requests while idle
        push_req(REQ_SPARE, 4'hF);
        push_req(REQ_PULSE, 4'h0);
        push_req(REQ_TICK, 4'hA);
        push_req(REQ_KEY, 4'd7);
        push_req(REQ_KEY, 4'd12);
        // wire count with stray keys in between, display shows 99
        push_req(REQ_KEY, KEY_STAR);
        push_req(REQ_KEY, 4'd13);
        push_req(REQ_KEY, 4'd9);
        push_req(REQ_KEY, 4'd15);
        push_req(REQ_KEY, 4'd9);
        // zero wire count: hash entry drops straight back to idle
        push_entry(KEY_STAR, 0);
        push_entry(KEY_HASH, 42);
        // one wire at reset settings, keys and ticks while feeding
        push_entry(KEY_STAR, 1);
        push_entry(KEY_HASH, 1);
        push_req(REQ_KEY, KEY_STAR);
        push_req(REQ_TICK, 4'd3);
        repeat (PPU_RESET) push_req(REQ_PULSE, 4'd5);
        // pulses and keys are ignored while cutting
        push_req(REQ_PULSE, 4'd8);
        push_req(REQ_KEY, KEY_HASH);
        repeat (HOLD_RESET) push_req(REQ_TICK, 4'($urandom_range(15)));
        wait_drained();

        // 99 wires of zero length, then a long wire at one pulse per unit
        write_reg(CFG_PPU, 16'd1);
        write_reg(CFG_HOLD, 16'd0);
        queue_batch(99, 0, 1'b1);
        queue_batch(1, 99, 1'b1);
        wait_drained();

        // widest divider with a short hold, no idling on either side
        calm = 1'b1;
        write_reg(CFG_PPU, 16'd255);
        write_reg(CFG_HOLD, 16'd3);
        queue_batch(1, 1, 1'b1);
        wait_drained();
        calm = 1'b0;

        // zero divider, hold of one, stray requests mixed in
        noise_pct = 12;
        write_reg(CFG_PPU, 16'd0);
        write_reg(CFG_HOLD, 16'd1);
        queue_batch(2, 3, 1'b1);
        queue_batch(1, 2, 1'b0);
        wait_drained();

        // random phases
        made     = 0;
        phase_no = 0;
        while (made < RANDOM_ITEMS) begin
            calm = (phase_no == 1);
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0:       write_reg(CFG_PPU, 16'd0);
                    1:       write_reg(CFG_PPU, 16'($urandom_range(8, 5)));
                    default: write_reg(CFG_PPU, 16'($urandom_range(3, 1)));
                endcase
            end
            if ($urandom_range(3) != 0) write_reg(CFG_HOLD, 16'($urandom_range(5)));
            repeat ($urandom_range(5, 2)) begin
                queue_batch(($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1),
                            $urandom_range(5), $urandom_range(9) != 0);
                repeat ($urandom_range(3)) push_noise(1'b1, 1'b1, 1'b0);
            end
            wait_drained();
            phase_no++;
        end
        calm = 1'b0;

        wait_drained();
        if (mismatches == 0) begin
            $display("wire_feed_cut_sequencer_top_tb passed");
        end else begin
            $display("wire_feed_cut_sequencer_top_tb failed");
        end
        $finish;
    end

endmodule

// File: wire_feed_cut_sequencer_top.f
rtl/wfcs_pkg.sv
rtl/wfcs_if.sv
rtl/wfcs_in_stage.sv
rtl/wfcs_ctrl.sv
rtl/wfcs_out_stage.sv
rtl/wire_feed_cut_sequencer_top.sv
rtl/wfcs_checker.sv
tb/wire_feed_cut_sequencer_top_tb.sv
